// ----- rtl/lowest_free_id_allocator_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef LOWEST_FREE_ID_ALLOCATOR_DEFINES_SVH
`define LOWEST_FREE_ID_ALLOCATOR_DEFINES_SVH

// check a property at every clock edge outside reset
`define LFA_CHECK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// check a same-cycle implication
`define LFA_CHECK_IMP(lbl, ante, cons, msg) \
	`LFA_CHECK(lbl, (ante) |-> (cons), msg)

`endif

// ----- rtl/lfa_pkg.sv -----
// ----------------------------------------------------------------------------
// lfa_pkg
// Types and constants of the lowest free identifier allocator.
// ----------------------------------------------------------------------------
package lfa_pkg;

	localparam int WORD_W = 32;
	localparam int IDX_W  = $clog2(WORD_W);

	localparam logic [1:0] OP_ALLOC = 2'd0;
	localparam logic [1:0] OP_FREE  = 2'd1;
	localparam logic [1:0] OP_QUERY = 2'd2;

	typedef struct packed {
		logic [1:0] operation;
		logic [7:0] id_in;
	} lfa_req_t;

	typedef struct packed {
		logic [7:0] result_id;
		logic       success;
		logic       assigned;
	} lfa_rsp_t;

	// request in flight along the row of cells
	typedef struct packed {
		logic       valid;
		logic       done;
		logic [1:0] operation;
		logic [7:0] id_in;
		logic [7:0] result_id;
		logic       success;
		logic       assigned;
	} tok_t;

endpackage

// ----- rtl/lfa_stream_if.sv -----
// ----------------------------------------------------------------------------
// lfa_stream_if
// Valid/ready channel with a typed payload.
// ----------------------------------------------------------------------------
interface lfa_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/lfa_cell.sv -----
// ----------------------------------------------------------------------------
// lfa_cell
// One 32-bit word of the free map; serves the request passing through it.
// ----------------------------------------------------------------------------
module lfa_cell import lfa_pkg::*; #(
	parameter int NUM_IDS  = 128,
	parameter int CELL_IDX = 0
) (
	input  logic clk,
	input  logic arst_n,
	input  logic advance,
	input  tok_t tok_in,
	output tok_t tok_q
);

	function automatic logic [WORD_W-1:0] reset_word();
		logic [WORD_W-1:0] v;
		for (int b = 0; b < WORD_W; b++) begin
			v[b] = (CELL_IDX * WORD_W + b) < NUM_IDS;
		end
		return v;
	endfunction

	function automatic logic [IDX_W-1:0] lowest_set(input logic [WORD_W-1:0] w);
		logic [IDX_W-1:0] p;
		p = '0;
		for (int b = WORD_W - 1; b >= 0; b--) begin
			if (w[b]) begin
				p = IDX_W'(b);
			end
		end
		return p;
	endfunction

	localparam logic [WORD_W-1:0] RST_WORD = reset_word();
	localparam logic [7:0]        BASE_ID  = 8'((CELL_IDX * WORD_W + 1) % 256);

	logic [WORD_W-1:0] word_q;
	logic [WORD_W-1:0] word_d;
	tok_t              tok_d;
	logic [IDX_W-1:0]  pick;
	logic [IDX_W-1:0]  bit_sel;
	logic [7:0]        id_m1;
	logic              hit;

	always_comb begin
		tok_d   = tok_in;
		word_d  = word_q;
		pick    = lowest_set(word_q);
		id_m1   = tok_in.id_in - 8'd1;
		bit_sel = id_m1[IDX_W-1:0];
		hit     = (tok_in.id_in != 8'd0) && (int'(tok_in.id_in) <= NUM_IDS)
			&& (int'(id_m1[7:IDX_W]) == CELL_IDX);
		if (tok_in.valid) begin
			unique case (tok_in.operation)
				OP_ALLOC: begin
					if (!tok_in.done && (|word_q)) begin
						word_d[pick]    = 1'b0;
						tok_d.result_id = BASE_ID + 8'(pick);
						tok_d.success   = 1'b1;
						tok_d.done      = 1'b1;
					end
				end
				OP_FREE: begin
					if (hit && !word_q[bit_sel]) begin
						word_d[bit_sel] = 1'b1;
						tok_d.success   = 1'b1;
					end
				end
				OP_QUERY: begin
					if (hit) begin
						tok_d.assigned = !word_q[bit_sel];
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q.valid <= 1'b0;
			word_q      <= RST_WORD;
		end else if (advance) begin
			tok_q <= tok_d;
			if (tok_in.valid) begin
				word_q <= word_d;
			end
		end
	end

endmodule

// ----- rtl/lowest_free_id_allocator.sv -----
// ----------------------------------------------------------------------------
// lowest_free_id_allocator
// Bitmap allocator of identifiers 1..NUM_IDS, lowest free first.
// ----------------------------------------------------------------------------
//  channel | dir | payload
//  req     | in  | operation, id_in
//  rsp     | out | result_id, success, assigned
//
//  A request walks a row of ceil(NUM_IDS/32) cells, one 32-bit map word per
//  cell and one cell per cycle while the row is not stalled; its result is
//  registered in each cell in turn and is offered from the last cell's
//  register; the next request is taken in the cycle its predecessor's
//  result transfers. Reset marks every identifier free at once. A stalled
//  result holds the whole row and req.ready.
// ----------------------------------------------------------------------------
`include "lowest_free_id_allocator_defines.svh"

module lowest_free_id_allocator import lfa_pkg::*; #(
	parameter int NUM_IDS = 128
) (
	input  logic                clk,
	input  logic                arst_n,
	lfa_stream_if.sink          req,
	lfa_stream_if.source        rsp
);

	localparam int NUM_CELLS = (NUM_IDS + WORD_W - 1) / WORD_W;

	tok_t                 cell_in [NUM_CELLS];
	tok_t                 cell_q  [NUM_CELLS];
	tok_t                 entry;
	logic [NUM_CELLS-1:0] tok_valid;
	logic                 busy_q;
	logic                 advance;
	logic                 in_xfer;
	logic                 out_xfer;

	assign out_xfer  = rsp.valid && rsp.ready;
	assign req.ready = !busy_q || out_xfer;
	assign in_xfer   = req.valid && req.ready;
	assign advance   = !(cell_q[NUM_CELLS-1].valid && !rsp.ready);

	always_comb begin
		entry.valid     = in_xfer;
		entry.done      = 1'b0;
		entry.operation = req.data.operation;
		entry.id_in     = req.data.id_in;
		entry.result_id = 8'd0;
		entry.success   = 1'b0;
		entry.assigned  = (req.data.operation == OP_QUERY)
			&& ((req.data.id_in == 8'd0) || (int'(req.data.id_in) > NUM_IDS));
		cell_in[0] = entry;
		for (int i = 1; i < NUM_CELLS; i++) begin
			cell_in[i] = cell_q[i-1];
		end
		for (int i = 0; i < NUM_CELLS; i++) begin
			tok_valid[i] = cell_q[i].valid;
		end
	end

	for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
		lfa_cell #(
			.NUM_IDS  (NUM_IDS),
			.CELL_IDX (i)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.advance (advance),
			.tok_in  (cell_in[i]),
			.tok_q   (cell_q[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (in_xfer) begin
			busy_q <= 1'b1;
		end else if (out_xfer) begin
			busy_q <= 1'b0;
		end
	end

	assign rsp.valid          = cell_q[NUM_CELLS-1].valid;
	assign rsp.data.result_id = cell_q[NUM_CELLS-1].result_id;
	assign rsp.data.success   = cell_q[NUM_CELLS-1].success;
	assign rsp.data.assigned  = cell_q[NUM_CELLS-1].assigned;

	`LFA_CHECK(a_one_in_flight, $countones(tok_valid) <= 1, "more than one request in the row")
	`LFA_CHECK(a_busy_matches, busy_q == (|tok_valid), "busy flag out of step with the row")
	`LFA_CHECK_IMP(a_stall_blocks, rsp.valid && !rsp.ready, !req.ready, "request taken while stalled")

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives allocate, free and query requests into the lowest free identifier
// allocator and checks every response against a bitmap model of the pool
// or a typed row's answer: a short directed table first, then random fill
// and drain sequences under several sender and receiver idle patterns.
// ----------------------------------------------------------------------------
module testbench;
	import lfa_pkg::*;

	localparam int NUM_IDS     = 128;
	localparam int LATENCY     = 4;
	localparam int CYCLE_LIMIT = 200000;
	localparam int RANDOM_ITEMS = 120;

	localparam logic [1:0] OP_NONE = 2'd3;

	typedef struct packed {
		lfa_req_t req;
		logic     typed;
		lfa_rsp_t rsp;
	} step_t;

	localparam int NUM_STEPS = 23;
	localparam step_t STEPS [NUM_STEPS] = '{
		'{'{OP_QUERY, 8'd0},   1'b1, '{8'd0, 1'b0, 1'b1}},
		'{'{OP_QUERY, 8'd255}, 1'b1, '{8'd0, 1'b0, 1'b1}},
		'{'{OP_QUERY, 8'd129}, 1'b1, '{8'd0, 1'b0, 1'b1}},
		'{'{OP_QUERY, 8'd128}, 1'b1, '{8'd0, 1'b0, 1'b0}},
		'{'{OP_QUERY, 8'd1},   1'b1, '{8'd0, 1'b0, 1'b0}},
		'{'{OP_FREE,  8'd1},   1'b1, '{8'd0, 1'b0, 1'b0}},
		'{'{OP_FREE,  8'd0},   1'b1, '{8'd0, 1'b0, 1'b0}},
		'{'{OP_FREE,  8'd129}, 1'b1, '{8'd0, 1'b0, 1'b0}},
		'{'{OP_FREE,  8'd255}, 1'b1, '{8'd0, 1'b0, 1'b0}},
		'{'{OP_NONE,  8'd255}, 1'b1, '{8'd0, 1'b0, 1'b0}},
		'{'{OP_ALLOC, 8'd0},   1'b1, '{8'd1, 1'b1, 1'b0}},
		'{'{OP_ALLOC, 8'd255}, 1'b1, '{8'd2, 1'b1, 1'b0}},
		'{'{OP_QUERY, 8'd1},   1'b0, '{8'd0, 1'b0, 1'b0}},
		'{'{OP_QUERY, 8'd2},   1'b0, '{8'd0, 1'b0, 1'b0}},
		'{'{OP_FREE,  8'd1},   1'b0, '{8'd0, 1'b0, 1'b0}},
		'{'{OP_FREE,  8'd1},   1'b1, '{8'd0, 1'b0, 1'b0}},
		'{'{OP_ALLOC, 8'd0},   1'b0, '{8'd0, 1'b0, 1'b0}},
		'{'{OP_ALLOC, 8'd170}, 1'b0, '{8'd0, 1'b0, 1'b0}},
		'{'{OP_QUERY, 8'd3},   1'b0, '{8'd0, 1'b0, 1'b0}},
		'{'{OP_NONE,  8'd0},   1'b0, '{8'd0, 1'b0, 1'b0}},
		'{'{OP_FREE,  8'd3},   1'b0, '{8'd0, 1'b0, 1'b0}},
		'{'{OP_QUERY, 8'd3},   1'b0, '{8'd0, 1'b0, 1'b0}},
		'{'{OP_FREE,  8'd128}, 1'b0, '{8'd0, 1'b0, 1'b0}}
	};

	logic clk;
	logic arst_n;

	lfa_stream_if #(.payload_t(lfa_req_t)) req_if ();
	lfa_stream_if #(.payload_t(lfa_rsp_t)) rsp_if ();

	lowest_free_id_allocator #(
		.NUM_IDS(NUM_IDS)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	bit [NUM_IDS:1] id_free;
	lfa_rsp_t       answers_due [$];
	int             errors;
	int             cycles;
	int             idle_pct;
	int             stall_pct;

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	function automatic lfa_rsp_t allocator_step(lfa_req_t r);
		lfa_rsp_t a;
		a = '0;
		case (r.operation)
			OP_ALLOC: begin
				for (int k = 1; k <= NUM_IDS; k++) begin
					if (id_free[k]) begin
						id_free[k] = 1'b0;
						a.result_id = 8'(k);
						a.success = 1'b1;
						break;
					end
				end
			end
			OP_FREE: begin
				if (r.id_in >= 1 && r.id_in <= NUM_IDS && !id_free[r.id_in]) begin
					id_free[r.id_in] = 1'b1;
					a.success = 1'b1;
				end
			end
			OP_QUERY: begin
				if (r.id_in == 0 || r.id_in > NUM_IDS)
					a.assigned = 1'b1;
				else
					a.assigned = !id_free[r.id_in];
			end
			default: begin
			end
		endcase
		return a;
	endfunction

	function automatic int taken_count();
		int n;
		n = 0;
		for (int k = 1; k <= NUM_IDS; k++)
			if (!id_free[k])
				n++;
		return n;
	endfunction

	function automatic lfa_req_t random_request(bit filling);
		lfa_req_t r;
		int       pick;
		int       start;
		int       k;
		pick = $urandom_range(0, 99);
		if (pick < 3)
			r.operation = OP_NONE;
		else if (filling)
			r.operation = (pick < 85) ? OP_ALLOC : (pick < 92) ? OP_FREE : OP_QUERY;
		else
			r.operation = (pick < 20) ? OP_ALLOC : (pick < 80) ? OP_FREE : OP_QUERY;
		r.id_in = 8'($urandom_range(0, 255));
		if (r.operation != OP_ALLOC && $urandom_range(0, 99) < 75) begin
			start = $urandom_range(1, NUM_IDS);
			for (int n = 0; n < NUM_IDS; n++) begin
				k = (start + n - 1) % NUM_IDS + 1;
				if (!id_free[k]) begin
					r.id_in = 8'(k);
					break;
				end
			end
		end
		return r;
	endfunction

	// idle at random, hold the item until its transfer, then queue its expected answer
	task automatic send_request(input lfa_req_t item, input logic typed, input lfa_rsp_t typed_rsp);
		lfa_rsp_t guess;
		while ($urandom_range(0, 99) < idle_pct) begin
			req_if.valid = 1'b0;
			@(negedge clk);
		end
		req_if.valid = 1'b1;
		req_if.data = item;
		do
			@(posedge clk);
		while (!req_if.ready);
		guess = allocator_step(item);
		answers_due.push_back(typed ? typed_rsp : guess);
		@(negedge clk);
	endtask

	task automatic drain_answers();
		req_if.valid = 1'b0;
		while (answers_due.size() != 0)
			@(posedge clk);
		repeat (LATENCY) @(posedge clk);
		@(negedge clk);
	endtask

	always @(negedge clk)
		rsp_if.ready <= ($urandom_range(0, 99) >= stall_pct);

	always @(posedge clk) begin
		lfa_rsp_t want;
		lfa_rsp_t got;
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			got = rsp_if.data;
			if (answers_due.size() == 0) begin
				$display("%0t unexpected transfer: result_id %0d success %0b assigned %0b",
					$time, got.result_id, got.success, got.assigned);
				errors++;
			end else begin
				want = answers_due.pop_front();
				if (got.result_id !== want.result_id) begin
					$display("%0t result_id: expected %0d, actual %0d",
						$time, want.result_id, got.result_id);
					errors++;
				end
				if (got.success !== want.success) begin
					$display("%0t success: expected %0b, actual %0b",
						$time, want.success, got.success);
					errors++;
				end
				if (got.assigned !== want.assigned) begin
					$display("%0t assigned: expected %0b, actual %0b",
						$time, want.assigned, got.assigned);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t timeout with %0d results outstanding", $time, answers_due.size());
			$display("lowest_free_id_allocator: mismatch");
			$finish;
		end
	end

	initial begin
		bit filling;
		int full_hits;
		int idle_set [4];
		int stall_set [4];
		idle_set = '{0, 56, 0, 15};
		stall_set = '{0, 0, 56, 15};
		errors = 0;
		cycles = 0;
		idle_pct = 0;
		stall_pct = 0;
		filling = 1'b1;
		full_hits = 0;
		id_free = '1;
		arst_n = 1'b0;
		req_if.valid = 1'b0;
		req_if.data = '0;
		rsp_if.ready = 1'b0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		for (int i = 0; i < NUM_STEPS; i++)
			send_request(STEPS[i].req, STEPS[i].typed, STEPS[i].rsp);
		drain_answers();

		for (int p = 0; p < 4; p++) begin
			idle_pct = idle_set[p];
			stall_pct = stall_set[p];
			for (int i = 0; i < RANDOM_ITEMS; i++) begin
				// fill the pool, knock on it while full, then drain it
				if (filling && taken_count() == NUM_IDS)
					full_hits++;
				if (full_hits >= 4) begin
					filling = 1'b0;
					full_hits = 0;
				end else if (!filling && taken_count() <= 4) begin
					filling = 1'b1;
				end
				send_request(random_request(filling), 1'b0, '0);
			end
			drain_answers();
		end

		repeat (4 * LATENCY) @(posedge clk);
		while (answers_due.size() != 0) begin
			$display("%0t missing result: result_id %0d success %0b assigned %0b", $time,
				answers_due[0].result_id, answers_due[0].success, answers_due[0].assigned);
			void'(answers_due.pop_front());
			errors++;
		end
		if (errors == 0) begin
			$display("lowest_free_id_allocator: match");
		end else begin
			$display("lowest_free_id_allocator: mismatch");
		end
		$finish;
	end

endmodule
